/* hw/rtl/mp2_pkg.sv */
// Package for the 2x2 stride-2 max pooling unit: sizes, register codes and
// the structs passed between the sequencer and the pooling datapath.
// No dependencies.
package mp2_pkg;

   localparam int DATA_W        = 16;
   localparam int MAX_IN_WIDTH  = 256;
   localparam int MAX_INNER     = 16;
   localparam int MAX_IN_HEIGHT = 4096;
   localparam int LINE_DEPTH    = (MAX_IN_WIDTH / 2) * MAX_INNER;
   localparam int LINE_AW       = $clog2(LINE_DEPTH);

   localparam int CHAN_W  = 4;
   localparam int COL_W   = 8;
   localparam int ROW_W   = 12;
   localparam int PLANE_W = 16;

   localparam int IN_WIDTH_W  = 9;
   localparam int IN_HEIGHT_W = 13;
   localparam int OUT_WIDTH_W = 8;
   localparam int OUT_HEIGHT_W = 12;
   localparam int INNER_W     = 5;
   localparam int PLANES_W    = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_CHANNELS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_COUNT    = 3'd5;

   typedef struct packed {
      logic [IN_WIDTH_W-1:0]   in_width;
      logic [IN_HEIGHT_W-1:0]  in_height;
      logic [OUT_WIDTH_W-1:0]  out_width;
      logic [OUT_HEIGHT_W-1:0] out_height;
      logic [INNER_W-1:0]      inner_channels;
      logic [PLANES_W-1:0]     plane_count;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] sample;
      logic [CHAN_W-1:0]        chan;
      logic [LINE_AW-1:0]       idx;
      logic                     act;
      logic                     odd_col;
      logic                     odd_row;
      logic                     fin;
   } item_type;

endpackage

/* hw/rtl/mp2_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
module mp2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/mp2_seq.sv */
// Stream position sequencer and input register for the max pooling unit.
// Depends on mp2_pkg.
module mp2_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  mp2_pkg::cfg_type                 cfg,
   input  logic                             adv,
   input  logic                             req_valid,
   input  logic signed [mp2_pkg::DATA_W-1:0] req_sample,
   output mp2_pkg::item_type                s1
);
   import mp2_pkg::*;

   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   item_type           s1_ff, s1_in;

   logic [INNER_W-1:0]      ic;
   logic [IN_WIDTH_W-1:0]   iw;
   logic [IN_HEIGHT_W-1:0]  ih;
   logic [PLANES_W-1:0]     pc;
   logic [OUT_WIDTH_W-1:0]  iw_half, ow;
   logic [OUT_HEIGHT_W-1:0] ih_half, oh;
   logic [IN_WIDTH_W-1:0]   ow2;
   logic [IN_HEIGHT_W-1:0]  oh2;
   logic                    accept;
   logic                    chan_last, col_last, row_last, plane_last;

   always_comb begin
      if (cfg.inner_channels == '0) begin
         ic = INNER_W'(1);
      end else if (cfg.inner_channels > INNER_W'(MAX_INNER)) begin
         ic = INNER_W'(MAX_INNER);
      end else begin
         ic = cfg.inner_channels;
      end
      if (cfg.in_width == '0) begin
         iw = IN_WIDTH_W'(1);
      end else if (cfg.in_width > IN_WIDTH_W'(MAX_IN_WIDTH)) begin
         iw = IN_WIDTH_W'(MAX_IN_WIDTH);
      end else begin
         iw = cfg.in_width;
      end
      if (cfg.in_height == '0) begin
         ih = IN_HEIGHT_W'(1);
      end else if (cfg.in_height > IN_HEIGHT_W'(MAX_IN_HEIGHT)) begin
         ih = IN_HEIGHT_W'(MAX_IN_HEIGHT);
      end else begin
         ih = cfg.in_height;
      end
      pc = (cfg.plane_count == '0) ? PLANES_W'(1) : cfg.plane_count;
   end

   assign iw_half = iw[IN_WIDTH_W-1:1];
   assign ih_half = ih[IN_HEIGHT_W-1:1];
   assign ow      = (cfg.out_width < iw_half) ? cfg.out_width : iw_half;
   assign oh      = (cfg.out_height < ih_half) ? cfg.out_height : ih_half;
   assign ow2     = {ow, 1'b0};
   assign oh2     = {oh, 1'b0};

   assign accept     = req_valid & adv;
   assign chan_last  = ({1'b0, chan_ff} + INNER_W'(1)) >= ic;
   assign col_last   = ({1'b0, col_ff} + IN_WIDTH_W'(1)) >= iw;
   assign row_last   = ({1'b0, row_ff} + IN_HEIGHT_W'(1)) >= ih;
   assign plane_last = ({1'b0, plane_ff} + (PLANES_W + 1)'(1)) >= {1'b0, pc};

   always_comb begin
      chan_in  = chan_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      plane_in = plane_ff;
      if (accept) begin
         if (chan_last) begin
            chan_in = '0;
            if (col_last) begin
               col_in = '0;
               if (row_last) begin
                  row_in   = '0;
                  plane_in = plane_last ? '0 : plane_ff + PLANE_W'(1);
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end else begin
            chan_in = chan_ff + CHAN_W'(1);
         end
      end
   end

   always_comb begin
      s1_in         = s1_ff;
      s1_in.valid   = s1_ff.valid;
      if (adv) begin
         s1_in.valid   = req_valid;
         s1_in.sample  = req_sample;
         s1_in.chan    = chan_ff;
         s1_in.idx     = LINE_AW'(col_ff[COL_W-1:1]) * LINE_AW'(ic) + LINE_AW'(chan_ff);
         s1_in.act     = ({1'b0, row_ff} < oh2) && ({1'b0, col_ff} < ow2) &&
                         ({1'b0, chan_ff} < ic);
         s1_in.odd_col = col_ff[0];
         s1_in.odd_row = row_ff[0];
         s1_in.fin     = (plane_ff == pc - PLANES_W'(1)) &&
                         ({1'b0, row_ff} == oh2 - IN_HEIGHT_W'(1)) &&
                         ({1'b0, col_ff} == ow2 - IN_WIDTH_W'(1)) &&
                         ({1'b0, chan_ff} == ic - INNER_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff        <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         plane_ff       <= '0;
         s1_ff.valid    <= 1'b0;
      end else begin
         chan_ff        <= chan_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         plane_ff       <= plane_in;
         s1_ff.valid    <= s1_in.valid;
      end
      s1_ff.sample  <= s1_in.sample;
      s1_ff.chan    <= s1_in.chan;
      s1_ff.idx     <= s1_in.idx;
      s1_ff.act     <= s1_in.act;
      s1_ff.odd_col <= s1_in.odd_col;
      s1_ff.odd_row <= s1_in.odd_row;
      s1_ff.fin     <= s1_in.fin;
   end

   assign s1 = s1_ff;

endmodule

/* hw/rtl/mp2_pool.sv */
// Pooling datapath: pair hold registers, line store access and result register.
// Depends on mp2_pkg and mp2_ram.
module mp2_pool (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  mp2_pkg::item_type                 s1,
   output logic                              rsp_valid,
   output logic signed [mp2_pkg::DATA_W-1:0] rsp_pooled,
   output logic                              rsp_final_res
);
   import mp2_pkg::*;

   logic signed [DATA_W-1:0] pair_hold_ff [MAX_INNER];
   logic signed [DATA_W-1:0] hold_q, pair_max;
   logic                     fire, hold_we, ram_we, ram_re;
   logic [DATA_W-1:0]        ram_rdata;
   logic signed [DATA_W-1:0] stored;

   logic                     s2_valid_ff, s2_valid_in;
   logic signed [DATA_W-1:0] s2_m_ff, s2_m_in;
   logic                     s2_fin_ff, s2_fin_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] pooled_ff, pooled_in;
   logic                     fin_ff, fin_in;

   assign hold_q   = pair_hold_ff[s1.chan];
   assign pair_max = (hold_q > s1.sample) ? hold_q : s1.sample;

   assign fire    = adv & s1.valid & s1.act;
   assign hold_we = fire & ~s1.odd_col;
   assign ram_we  = fire & s1.odd_col & ~s1.odd_row;
   assign ram_re  = fire & s1.odd_col & s1.odd_row;

   mp2_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1.idx),
      .wdata (pair_max),
      .re    (ram_re),
      .raddr (s1.idx),
      .rdata (ram_rdata)
   );

   assign stored = $signed(ram_rdata);

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_m_in      = s2_m_ff;
      s2_fin_in    = s2_fin_ff;
      out_valid_in = out_valid_ff;
      pooled_in    = pooled_ff;
      fin_in       = fin_ff;
      if (adv) begin
         s2_valid_in  = s1.valid & s1.act & s1.odd_col & s1.odd_row;
         s2_m_in      = pair_max;
         s2_fin_in    = s1.fin;
         out_valid_in = s2_valid_ff;
         pooled_in    = (stored > s2_m_ff) ? stored : s2_m_ff;
         fin_in       = s2_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (hold_we) begin
         pair_hold_ff[s1.chan] <= s1.sample;
      end
      s2_m_ff   <= s2_m_in;
      s2_fin_ff <= s2_fin_in;
      pooled_ff <= pooled_in;
      fin_ff    <= fin_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pooled    = pooled_ff;
   assign rsp_final_res = fin_ff;

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({hold_we, ram_we, ram_re}))
      else $error("pair hold and line store accessed by one transaction twice");

   a_read_pairs_result: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> s2_valid_ff)
      else $error("line store read without a pending result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      adv |=> (out_valid_ff == $past(s2_valid_ff)))
      else $error("result register lost or invented a transaction");

endmodule

/* hw/rtl/max_pool_2x2_stride2_blocked_unit.sv */
// 2x2, stride-2 max pooling over a channel-blocked tensor streamed one element
// per transaction (plane, row, column, inner channel). One element is taken
// every cycle unless a result waits with rsp_ready low; a result passes from its
// last element through the input register, the registered read port of the
// 2048-entry line store and the result register before it can be taken.
// A waiting result holds the whole pipeline. The line store has no clearing pass.
// Depends on mp2_pkg, mp2_seq, mp2_pool and mp2_ram.
module max_pool_2x2_stride2_blocked_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mp2_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mp2_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mp2_pkg::DATA_W-1:0]     req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mp2_pkg::DATA_W-1:0]     rsp_pooled,
   output logic                                  rsp_final_res
);
   import mp2_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type s1;
   logic     adv;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_IN_WIDTH:       cfg_in.in_width       = csr_wdata[IN_WIDTH_W-1:0];
            REG_IN_HEIGHT:      cfg_in.in_height      = csr_wdata[IN_HEIGHT_W-1:0];
            REG_OUT_WIDTH:      cfg_in.out_width      = csr_wdata[OUT_WIDTH_W-1:0];
            REG_OUT_HEIGHT:     cfg_in.out_height     = csr_wdata[OUT_HEIGHT_W-1:0];
            REG_INNER_CHANNELS: cfg_in.inner_channels = csr_wdata[INNER_W-1:0];
            REG_PLANE_COUNT:    cfg_in.plane_count    = csr_wdata[PLANES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width       <= IN_WIDTH_W'(2);
         cfg_ff.in_height      <= IN_HEIGHT_W'(2);
         cfg_ff.out_width      <= OUT_WIDTH_W'(1);
         cfg_ff.out_height     <= OUT_HEIGHT_W'(1);
         cfg_ff.inner_channels <= INNER_W'(1);
         cfg_ff.plane_count    <= PLANES_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign adv       = ~rsp_valid | rsp_ready;
   assign req_ready = adv;

   mp2_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .adv        (adv),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .s1         (s1)
   );

   mp2_pool u_pool (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .s1            (s1),
      .rsp_valid     (rsp_valid),
      .rsp_pooled    (rsp_pooled),
      .rsp_final_res (rsp_final_res)
   );

endmodule
